// File: sv/rgb_image_scaler_macros.svh
// Assertion macros shared by the scaler modules.
`ifndef RGB_IMAGE_SCALER_MACROS_SVH
`define RGB_IMAGE_SCALER_MACROS_SVH

// Check a same-cycle implication on the rising clock edge, off during reset.
`define RIS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check a next-cycle implication on the rising clock edge, off during reset.
`define RIS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/ris_pkg.sv
// Shared constants, codes and types of the RGB image scaler.
`default_nettype none
package ris_pkg;
  localparam int MAX_SRC_WIDTH   = 128;
  localparam int MAX_SRC_HEIGHT  = 128;
  localparam int BYTES_PER_PIXEL = 3;

  localparam int XW          = $clog2(MAX_SRC_WIDTH);
  localparam int YW          = $clog2(MAX_SRC_HEIGHT);
  localparam int ADDR_W      = XW + YW;
  localparam int STORE_DEPTH = MAX_SRC_WIDTH * MAX_SRC_HEIGHT;

  localparam int CH_W    = 8;
  localparam int PIX_W   = CH_W * BYTES_PER_PIXEL;
  localparam int SRC_W   = 8;
  localparam int DST_W   = 12;
  localparam int FRAC_W  = 16;
  localparam int UV_W    = 8;
  localparam int RATIO_W = SRC_W + FRAC_W;
  localparam int PROD_W  = DST_W + RATIO_W;
  localparam int HI_W    = PROD_W - FRAC_W;
  localparam int NUM_W   = DST_W + SRC_W;
  localparam int REM_W   = DST_W + XW + 1;
  localparam int QCNT_W  = $clog2(XW + 1);
  localparam int W_W     = FRAC_W + 1;
  localparam int ACC_W   = FRAC_W + CH_W;
  localparam int HALF    = 1 << 15;

  localparam logic [W_W-1:0] W_ONE = W_W'(1) << FRAC_W;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOURCE_WIDTH  = 2'd0,
    CFG_SOURCE_HEIGHT = 2'd1,
    CFG_TARGET_WIDTH  = 2'd2,
    CFG_TARGET_HEIGHT = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_ERR   = 2'd1,
    KIND_NEAR  = 2'd2,
    KIND_BILIN = 2'd3
  } kind_t;

  // Effective sizes and scaling mode
  typedef struct packed {
    logic [SRC_W-1:0] sw;
    logic [SRC_W-1:0] sh;
    logic [DST_W-1:0] tw;
    logic [DST_W-1:0] th;
    logic             up;
  } scale_cfg_t;

  // One request from the address stage to the store access stage
  typedef struct packed {
    kind_t             kind;
    logic              we;
    logic [ADDR_W-1:0] addr0;
    logic [ADDR_W-1:0] addr1;
    logic [ADDR_W-1:0] addr2;
    logic [ADDR_W-1:0] addr3;
    logic [UV_W-1:0]   u;
    logic [UV_W-1:0]   v;
    logic [PIX_W-1:0]  wdata;
  } fetch_req_t;
endpackage
`default_nettype wire

// File: sv/rgb_image_scaler.sv
// Top level of the RGB888 image scaler: registers, ratio dividers, datapath.
//
//   channel   handshake               payload
//   request   start / busy            opcode, pos_x, pos_y, red_in, green_in, blue_in
//   config    cfg_valid / cfg_ready   cfg_index, cfg_data
//   result    done (one-cycle strobe) red_out, green_out, blue_out, coord_error
//
// A load takes at most one write on the store port; a bilinear pixel takes four reads (one
// neighbor read per cycle on the single-port source store), so a steady
// stream of bilinear requests waits on the store reads. A nearest pixel
// waits in the address stage for the 7-step quotient loop. A request passes
// stage A, stage B, the issue stage and the store read; the accumulate
// stage then registers the result together with done.
// After reset and after each register write, busy stays high while the
// two 24-step ratio dividers load and run. Results cannot be stalled.
`default_nettype none
module rgb_image_scaler (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            opcode,
  input  wire logic [11:0]                     pos_x,
  input  wire logic [11:0]                     pos_y,
  input  wire logic [7:0]                      red_in,
  input  wire logic [7:0]                      green_in,
  input  wire logic [7:0]                      blue_in,
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [ris_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ris_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                                 done,
  output logic [7:0]                           red_out,
  output logic [7:0]                           green_out,
  output logic [7:0]                           blue_out,
  output logic                                 coord_error
);
  import ris_pkg::*;

  logic [SRC_W-1:0] source_width;
  logic [SRC_W-1:0] source_height;
  logic [DST_W-1:0] target_width;
  logic [DST_W-1:0] target_height;

  scale_cfg_t         cfg;
  logic               cfg_write;
  logic               div_busy_x;
  logic               div_busy_y;
  logic [RATIO_W-1:0] ratio_x;
  logic [RATIO_W-1:0] ratio_y;
  logic               req_valid;
  logic               req_ready;
  fetch_req_t         req;

  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid && cfg_ready;

  // Write the size registers
  always_ff @(posedge clk) begin
    if (rst) begin
      source_width  <= SRC_W'(128);
      source_height <= SRC_W'(128);
      target_width  <= DST_W'(128);
      target_height <= DST_W'(128);
    end else if (cfg_write) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_SOURCE_WIDTH:  source_width  <= cfg_data[SRC_W-1:0];
        CFG_SOURCE_HEIGHT: source_height <= cfg_data[SRC_W-1:0];
        CFG_TARGET_WIDTH:  target_width  <= cfg_data[DST_W-1:0];
        CFG_TARGET_HEIGHT: target_height <= cfg_data[DST_W-1:0];
      endcase
    end
  end

  // Clamp sizes into their usable range and pick the mode
  always_comb begin
    if (source_width == '0) begin
      cfg.sw = SRC_W'(1);
    end else if (int'(source_width) > MAX_SRC_WIDTH) begin
      cfg.sw = SRC_W'(MAX_SRC_WIDTH);
    end else begin
      cfg.sw = source_width;
    end
    if (source_height == '0) begin
      cfg.sh = SRC_W'(1);
    end else if (int'(source_height) > MAX_SRC_HEIGHT) begin
      cfg.sh = SRC_W'(MAX_SRC_HEIGHT);
    end else begin
      cfg.sh = source_height;
    end
    cfg.tw = (target_width == '0) ? DST_W'(1) : target_width;
    cfg.th = (target_height == '0) ? DST_W'(1) : target_height;
    cfg.up = (DST_W'(cfg.sw) < cfg.tw) || (DST_W'(cfg.sh) < cfg.th);
  end

  ris_ratio_div u_div_x (
    .clk  (clk),
    .rst  (rst),
    .kick (cfg_write),
    .src  (cfg.sw),
    .dst  (cfg.tw),
    .busy (div_busy_x),
    .ratio(ratio_x)
  );

  ris_ratio_div u_div_y (
    .clk  (clk),
    .rst  (rst),
    .kick (cfg_write),
    .src  (cfg.sh),
    .dst  (cfg.th),
    .busy (div_busy_y),
    .ratio(ratio_y)
  );

  ris_addr_gen u_addr_gen (
    .clk      (clk),
    .rst      (rst),
    .hold     (div_busy_x || div_busy_y),
    .start    (start),
    .busy     (busy),
    .opcode   (opcode),
    .pos_x    (pos_x),
    .pos_y    (pos_y),
    .red_in   (red_in),
    .green_in (green_in),
    .blue_in  (blue_in),
    .cfg      (cfg),
    .ratio_x  (ratio_x),
    .ratio_y  (ratio_y),
    .req_valid(req_valid),
    .req      (req),
    .req_ready(req_ready)
  );

  ris_fetch u_fetch (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req        (req),
    .req_ready  (req_ready),
    .done       (done),
    .red_out    (red_out),
    .green_out  (green_out),
    .blue_out   (blue_out),
    .coord_error(coord_error)
  );
endmodule
`default_nettype wire

// File: sv/ris_ram.sv
// Generic single-port RAM with registered read.
`default_nettype none
module ris_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     en,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write or read one entry
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end
endmodule
`default_nettype wire

// File: sv/ris_ratio_div.sv
// Restoring divider for the 8.16 step ratio of one axis.
`default_nettype none
module ris_ratio_div (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      kick,
  input  wire logic [ris_pkg::SRC_W-1:0] src,
  input  wire logic [ris_pkg::DST_W-1:0] dst,
  output logic                           busy,
  output logic [ris_pkg::RATIO_W-1:0]    ratio
);
  import ris_pkg::*;

  localparam int CNT_W = $clog2(RATIO_W);

  logic               pend;
  logic               run;
  logic [CNT_W-1:0]   cnt;
  logic [RATIO_W-1:0] num;
  logic [DST_W-1:0]   rem;
  logic [RATIO_W-1:0] q;
  logic [DST_W:0]     trial;
  logic               ge;
  logic [RATIO_W-1:0] q_next;

  // Shift in one numerator bit and try the subtract
  always_comb begin
    trial  = {rem, num[RATIO_W-1]};
    ge     = trial >= {1'b0, dst};
    q_next = {q[RATIO_W-2:0], ge};
  end

  // Control: restart after reset or a register write
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b1;
      run  <= 1'b0;
      cnt  <= '0;
    end else if (kick) begin
      pend <= 1'b1;
      run  <= 1'b0;
    end else if (pend) begin
      pend <= 1'b0;
      run  <= 1'b1;
      cnt  <= '0;
    end else if (run) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == CNT_W'(RATIO_W - 1)) begin
        run <= 1'b0;
      end
    end
  end

  // Datapath: one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (pend) begin
      num <= {src, FRAC_W'(0)};
      rem <= '0;
      q   <= '0;
    end else if (run) begin
      num <= num << 1;
      rem <= ge ? DST_W'(trial - {1'b0, dst}) : DST_W'(trial);
      q   <= q_next;
      if (cnt == CNT_W'(RATIO_W - 1)) begin
        ratio <= q_next + RATIO_W'(1);
      end
    end
  end

  assign busy = pend | run;
endmodule
`default_nettype wire

// File: sv/ris_addr_gen.sv
// Request intake, position multiply, nearest divide and store address generation.
`default_nettype none
`include "rgb_image_scaler_macros.svh"
module ris_addr_gen (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        hold,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic                        opcode,
  input  wire logic [11:0]                 pos_x,
  input  wire logic [11:0]                 pos_y,
  input  wire logic [7:0]                  red_in,
  input  wire logic [7:0]                  green_in,
  input  wire logic [7:0]                  blue_in,
  input  wire ris_pkg::scale_cfg_t         cfg,
  input  wire logic [ris_pkg::RATIO_W-1:0] ratio_x,
  input  wire logic [ris_pkg::RATIO_W-1:0] ratio_y,
  output logic                             req_valid,
  output ris_pkg::fetch_req_t              req,
  input  wire logic                        req_ready
);
  import ris_pkg::*;

  // Stage A: accepted request and products
  logic              a_v;
  kind_t             a_kind;
  logic              a_we;
  logic [ADDR_W-1:0] a_waddr;
  logic [PIX_W-1:0]  a_wdata;
  logic [PROD_W-1:0] a_prod_x;
  logic [PROD_W-1:0] a_prod_y;
  logic [NUM_W-1:0]  a_num_x;
  logic [NUM_W-1:0]  a_num_y;

  // Stage B: positions and nearest quotients
  logic              b_v;
  kind_t             b_kind;
  logic              b_we;
  logic [ADDR_W-1:0] b_waddr;
  logic [PIX_W-1:0]  b_wdata;
  logic [PROD_W-1:0] b_pos_x;
  logic [PROD_W-1:0] b_pos_y;
  logic [REM_W-1:0]  b_rem_x;
  logic [REM_W-1:0]  b_rem_y;
  logic [XW-1:0]     b_qx;
  logic [YW-1:0]     b_qy;
  logic [QCNT_W-1:0] b_cnt;

  logic accept;
  logic a_adv;
  logic b_adv;
  logic b_done;
  logic in_err;
  kind_t in_kind;

  logic [REM_W-1:0] dx;
  logic [REM_W-1:0] dy;
  logic             gx;
  logic             gy;

  logic [HI_W-1:0] hi_x;
  logic [HI_W-1:0] hi_y;
  logic [HI_W-1:0] sw_ext;
  logic [HI_W-1:0] sh_ext;
  logic [XW-1:0]   x0;
  logic [XW-1:0]   x1;
  logic [YW-1:0]   y0;
  logic [YW-1:0]   y1;

  // Decide the request kind at intake
  always_comb begin
    in_err = (pos_x >= cfg.tw) || (pos_y >= cfg.th);
    if (!opcode) begin
      in_kind = KIND_LOAD;
    end else if (in_err) begin
      in_kind = KIND_ERR;
    end else if (cfg.up) begin
      in_kind = KIND_BILIN;
    end else begin
      in_kind = KIND_NEAR;
    end
  end

  assign b_done = (b_kind != KIND_NEAR) || (b_cnt == QCNT_W'(XW));
  assign b_adv  = b_v && b_done && req_ready;
  assign a_adv  = a_v && (!b_v || b_adv);
  assign busy   = hold || (a_v && !a_adv);
  assign accept = start && !busy;

  // Advance the valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
      b_v <= 1'b0;
    end else begin
      if (accept) begin
        a_v <= 1'b1;
      end else if (a_adv) begin
        a_v <= 1'b0;
      end
      if (a_adv) begin
        b_v <= 1'b1;
      end else if (b_adv) begin
        b_v <= 1'b0;
      end
    end
  end

  // Stage A: capture the request, multiply positions
  always_ff @(posedge clk) begin
    if (accept) begin
      a_kind   <= in_kind;
      a_we     <= (int'(pos_x) < MAX_SRC_WIDTH) && (int'(pos_y) < MAX_SRC_HEIGHT);
      a_waddr  <= {pos_y[YW-1:0], pos_x[XW-1:0]};
      a_wdata  <= {blue_in, green_in, red_in};
      a_prod_x <= pos_x * ratio_x;
      a_prod_y <= pos_y * ratio_y;
      a_num_x  <= pos_x * cfg.sw;
      a_num_y  <= pos_y * cfg.sh;
    end
  end

  // Nearest divide: fixed divisor, shifting remainder
  always_comb begin
    dx = REM_W'(cfg.tw) << (XW - 1);
    dy = REM_W'(cfg.th) << (YW - 1);
    gx = b_rem_x >= dx;
    gy = b_rem_y >= dy;
  end

  // Stage B: add the center offset, or iterate the nearest divide
  always_ff @(posedge clk) begin
    if (a_adv) begin
      b_kind  <= a_kind;
      b_we    <= a_we;
      b_waddr <= a_waddr;
      b_wdata <= a_wdata;
      b_pos_x <= a_prod_x + PROD_W'(ratio_x >> 1) + PROD_W'(HALF);
      b_pos_y <= a_prod_y + PROD_W'(ratio_y >> 1) + PROD_W'(HALF);
      b_rem_x <= REM_W'(a_num_x);
      b_rem_y <= REM_W'(a_num_y);
      b_qx    <= '0;
      b_qy    <= '0;
      b_cnt   <= '0;
    end else if (b_v && !b_done) begin
      b_rem_x <= (gx ? b_rem_x - dx : b_rem_x) << 1;
      b_rem_y <= (gy ? b_rem_y - dy : b_rem_y) << 1;
      b_qx    <= XW'({b_qx, gx});
      b_qy    <= YW'({b_qy, gy});
      b_cnt   <= b_cnt + QCNT_W'(1);
    end
  end

  // Clamp the four neighbors to the image edges
  always_comb begin
    hi_x   = b_pos_x[PROD_W-1:FRAC_W];
    hi_y   = b_pos_y[PROD_W-1:FRAC_W];
    sw_ext = HI_W'(cfg.sw);
    sh_ext = HI_W'(cfg.sh);
    if (hi_x == '0) begin
      x0 = '0;
    end else if ((hi_x - HI_W'(1)) >= sw_ext) begin
      x0 = XW'(cfg.sw - SRC_W'(1));
    end else begin
      x0 = XW'(hi_x - HI_W'(1));
    end
    x1 = (hi_x >= sw_ext) ? XW'(cfg.sw - SRC_W'(1)) : XW'(hi_x);
    if (hi_y == '0) begin
      y0 = '0;
    end else if ((hi_y - HI_W'(1)) >= sh_ext) begin
      y0 = YW'(cfg.sh - SRC_W'(1));
    end else begin
      y0 = YW'(hi_y - HI_W'(1));
    end
    y1 = (hi_y >= sh_ext) ? YW'(cfg.sh - SRC_W'(1)) : YW'(hi_y);
  end

  // Build the store request
  always_comb begin
    req.kind  = b_kind;
    req.we    = b_we;
    req.wdata = b_wdata;
    req.u     = b_pos_x[FRAC_W-1 -: UV_W];
    req.v     = b_pos_y[FRAC_W-1 -: UV_W];
    req.addr1 = {y0, x1};
    req.addr2 = {y1, x0};
    req.addr3 = {y1, x1};
    case (b_kind)
      KIND_LOAD: req.addr0 = b_waddr;
      KIND_NEAR: req.addr0 = {b_qy, b_qx};
      default:   req.addr0 = {y0, x0};
    endcase
  end

  assign req_valid = b_v && b_done;

  `RIS_ASSERT_IMP(a_near_in_range, b_v && (b_kind == KIND_NEAR) && b_done, (SRC_W'(b_qx) < cfg.sw) && (SRC_W'(b_qy) < cfg.sh), "nearest index beyond source size")
  `RIS_ASSERT_NXT(a_intake_held, start && !busy, a_v, "accepted request not captured")
endmodule
`default_nettype wire

// File: sv/ris_fetch.sv
// Source store access, weighting and accumulation of the result pixel.
`default_nettype none
`include "rgb_image_scaler_macros.svh"
module ris_fetch (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  input  wire ris_pkg::fetch_req_t req,
  output logic                     req_ready,
  output logic                     done,
  output logic [7:0]               red_out,
  output logic [7:0]               green_out,
  output logic [7:0]               blue_out,
  output logic                     coord_error
);
  import ris_pkg::*;

  // Issue stage
  logic       f_v;
  fetch_req_t f_req;
  logic [1:0] f_cnt;
  logic       f_last;

  // Accumulate stage, aligned with read data
  logic           t_v;
  logic           t_rd;
  logic           t_first;
  logic           t_last;
  logic           t_err;
  logic [W_W-1:0] t_w;

  logic [ACC_W-1:0] acc [BYTES_PER_PIXEL];
  logic [ACC_W-1:0] sum [BYTES_PER_PIXEL];
  logic [PIX_W-1:0] out_pix;

  logic              ram_en;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [PIX_W-1:0]  rdata;
  logic [PIX_W-1:0]  pix;

  logic [2*UV_W-1:0] w3;
  logic [W_W-1:0]    uu;
  logic [W_W-1:0]    vv;
  logic [W_W-1:0]    w_sel;

  assign f_last    = (f_req.kind == KIND_BILIN) ? (f_cnt == 2'd3) : 1'b1;
  assign req_ready = !f_v || f_last;

  // Hold a request for its reads
  always_ff @(posedge clk) begin
    if (rst) begin
      f_v   <= 1'b0;
      f_cnt <= '0;
    end else if (req_valid && req_ready) begin
      f_v   <= 1'b1;
      f_cnt <= '0;
    end else if (f_v && f_last) begin
      f_v <= 1'b0;
    end else if (f_v) begin
      f_cnt <= f_cnt + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      f_req <= req;
    end
  end

  // Select the neighbor and its weight
  always_comb begin
    w3 = f_req.u * f_req.v;
    uu = W_W'({f_req.u, 8'd0});
    vv = W_W'({f_req.v, 8'd0});
    ram_addr = f_req.addr0;
    w_sel    = W_ONE;
    case (f_req.kind)
      KIND_BILIN: begin
        case (f_cnt)
          2'd0: begin
            ram_addr = f_req.addr0;
            w_sel    = W_ONE - uu - vv + W_W'(w3);
          end
          2'd1: begin
            ram_addr = f_req.addr1;
            w_sel    = uu - W_W'(w3);
          end
          2'd2: begin
            ram_addr = f_req.addr2;
            w_sel    = vv - W_W'(w3);
          end
          default: begin
            ram_addr = f_req.addr3;
            w_sel    = W_W'(w3);
          end
        endcase
      end
      KIND_ERR: w_sel = '0;
      default:  w_sel = W_ONE;
    endcase
    ram_we = f_v && (f_req.kind == KIND_LOAD) && f_req.we;
    ram_en = ram_we || (f_v && ((f_req.kind == KIND_NEAR) || (f_req.kind == KIND_BILIN)));
  end

  ris_ram #(
    .WIDTH(PIX_W),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk  (clk),
    .en   (ram_en),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(f_req.wdata),
    .rdata(rdata)
  );

  // Tag the read so it meets its data
  always_ff @(posedge clk) begin
    if (rst) begin
      t_v <= 1'b0;
    end else begin
      t_v <= f_v && (f_req.kind != KIND_LOAD);
    end
  end

  always_ff @(posedge clk) begin
    t_rd    <= f_req.kind != KIND_ERR;
    t_first <= f_cnt == 2'd0;
    t_last  <= f_last;
    t_err   <= f_req.kind == KIND_ERR;
    t_w     <= w_sel;
  end

  // Weight and sum each channel
  always_comb begin
    pix = t_rd ? rdata : '0;
    for (int c = 0; c < BYTES_PER_PIXEL; c++) begin
      sum[c] = ACC_W'((t_first ? ACC_W'(0) : acc[c]) + t_w * pix[c*CH_W +: CH_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (t_v) begin
      for (int c = 0; c < BYTES_PER_PIXEL; c++) begin
        acc[c] <= sum[c];
        out_pix[c*CH_W +: CH_W] <= sum[c][ACC_W-1 -: CH_W];
      end
    end
    if (t_v && t_last) begin
      coord_error <= t_err;
    end
  end

  // Strobe the finished pixel
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= t_v && t_last;
    end
  end

  assign red_out   = out_pix[0 +: CH_W];
  assign green_out = out_pix[CH_W +: CH_W];
  assign blue_out  = out_pix[2*CH_W +: CH_W];

  `RIS_ASSERT_NXT(a_last_strobes, t_v && t_last, done, "final read gave no result")
  `RIS_ASSERT_IMP(a_err_black, done && coord_error, (red_out == 8'd0) && (green_out == 8'd0) && (blue_out == 8'd0), "flagged pixel not zero")
  `RIS_ASSERT_NXT(a_bilin_hold, f_v && (f_req.kind == KIND_BILIN) && (f_cnt == 2'd0), f_v, "bilinear request dropped early")
endmodule
`default_nettype wire

// File: verif/tb_rgb_image_scaler.sv
// Self-checking testbench for the RGB888 image scaler: directed table, then random phases.
`default_nettype none
module tb_rgb_image_scaler;
  timeunit 1ns;
  timeprecision 1ps;
  import ris_pkg::*;

  localparam bit OP_LOAD    = 1'b0;
  localparam bit OP_COMPUTE = 1'b1;
  localparam int DRAIN_CYCLES = 30;
  localparam int PHASES = 24;
  localparam int PHASE_ITEMS = 60;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       err;
  } pixel_t;

  typedef struct {
    bit         op;
    bit [11:0]  x;
    bit [11:0]  y;
    bit [7:0]   r;
    bit [7:0]   g;
    bit [7:0]   b;
    bit         typed;
    pixel_t     want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = 1'b0;
  logic [11:0] pos_x = '0;
  logic [11:0] pos_y = '0;
  logic [7:0] red_in = '0;
  logic [7:0] green_in = '0;
  logic [7:0] blue_in = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic done;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic coord_error;

  // Shadow registers and frame store of the predictor
  logic [7:0]  src_w_reg = 8'd128;
  logic [7:0]  src_h_reg = 8'd128;
  logic [11:0] dst_w_reg = 12'd128;
  logic [11:0] dst_h_reg = 12'd128;
  logic [23:0] frame_mem [STORE_DEPTH];
  bit          written [STORE_DEPTH];

  pixel_t pending_px [$];
  int fail_count = 0;
  int max_gap = 10;

  rgb_image_scaler dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .pos_x(pos_x), .pos_y(pos_y), .red_in(red_in), .green_in(green_in),
    .blue_in(blue_in), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done), .red_out(red_out),
    .green_out(green_out), .blue_out(blue_out), .coord_error(coord_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #50ms;
    $display("FAIL rgb_image_scaler");
    $finish;
  end

  task automatic report(string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  function automatic int unsigned eff_src(logic [7:0] v);
    if (v == 0) return 1;
    if (v > MAX_SRC_WIDTH) return MAX_SRC_WIDTH;
    return v;
  endfunction

  function automatic int unsigned eff_dst(logic [11:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  // Source position of a destination index: floored integer part and 8-bit fraction
  function automatic void axis_map(int unsigned d, int unsigned src, int unsigned dst,
                                   output int ip, output int unsigned frac);
    longint ratio;
    longint off;
    longint p;
    ratio = ((longint'(src) << 16) / dst) + 1;
    off = (ratio >>> 1) - 32768;
    p = longint'(d) * ratio + off + 65536;
    ip = int'(p >>> 16) - 1;
    frac = (int'(p) & 16'hFFFF) >> 8;
  endfunction

  function automatic int unsigned clamp_to(int i, int unsigned n);
    if (i < 0) return 0;
    if (i >= int'(n)) return n - 1;
    return i;
  endfunction

  function automatic logic [23:0] fetch(int unsigned x, int unsigned y);
    return frame_mem[y * MAX_SRC_WIDTH + x];
  endfunction

  // Scaled pixel at a destination coordinate under the current settings
  function automatic pixel_t scale_pixel(int unsigned x, int unsigned y);
    int unsigned sw, sh, tw, th, u, v, x0, x1, y0, y1, w0, w1, w2, w3, sx, sy;
    int ix, iy;
    logic [23:0] p00, p10, p01, p11, p;
    int unsigned acc [3];
    pixel_t res;
    sw = eff_src(src_w_reg);
    sh = eff_src(src_h_reg);
    tw = eff_dst(dst_w_reg);
    th = eff_dst(dst_h_reg);
    res = '0;
    if (x >= tw || y >= th) begin
      res.err = 1'b1;
    end else if (sw < tw || sh < th) begin
      axis_map(x, sw, tw, ix, u);
      axis_map(y, sh, th, iy, v);
      x0 = clamp_to(ix, sw);
      x1 = clamp_to(ix + 1, sw);
      y0 = clamp_to(iy, sh);
      y1 = clamp_to(iy + 1, sh);
      p00 = fetch(x0, y0);
      p10 = fetch(x1, y0);
      p01 = fetch(x0, y1);
      p11 = fetch(x1, y1);
      w3 = u * v;
      w2 = (u << 8) - w3;
      w1 = (v << 8) - w3;
      w0 = 65536 - w1 - w2 - w3;
      for (int c = 0; c < 3; c++) begin
        acc[c] = (w0 * p00[8*c +: 8] + w2 * p10[8*c +: 8] + w1 * p01[8*c +: 8]
                  + w3 * p11[8*c +: 8]) >> 16;
      end
      res.red = acc[0][7:0];
      res.green = acc[1][7:0];
      res.blue = acc[2][7:0];
    end else begin
      sx = 32'((longint'(x) * sw) / tw);
      sy = 32'((longint'(y) * sh) / th);
      p = fetch(sx, sy);
      res.red = p[7:0];
      res.green = p[15:8];
      res.blue = p[23:16];
    end
    return res;
  endfunction

  // Drive one request from a falling edge and hold it until accepted
  task automatic send_request(bit op, bit [11:0] x, bit [11:0] y, bit [7:0] r,
                              bit [7:0] g, bit [7:0] b, bit typed, pixel_t want);
    int gap;
    gap = $urandom_range(0, max_gap);
    repeat (gap) begin
      start = 1'b0;
      @(negedge clk);
    end
    start = 1'b1;
    opcode = op;
    pos_x = x;
    pos_y = y;
    red_in = r;
    green_in = g;
    blue_in = b;
    do @(posedge clk); while (busy);
    if (op == OP_COMPUTE) begin
      pending_px.push_back(typed ? want : scale_pixel(x, y));
    end else if (x < MAX_SRC_WIDTH && y < MAX_SRC_HEIGHT) begin
      frame_mem[y * MAX_SRC_WIDTH + x] = {b, g, r};
      written[y * MAX_SRC_WIDTH + x] = 1'b1;
    end
    @(negedge clk);
  endtask

  task automatic load_random(bit [11:0] x, bit [11:0] y);
    send_request(OP_LOAD, x, y, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
  endtask

  // Hold off until every result is back, then let a trailing load drain
  task automatic wait_idle();
    start = 1'b0;
    while (pending_px.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [11:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_SOURCE_WIDTH:  src_w_reg = data[7:0];
      CFG_SOURCE_HEIGHT: src_h_reg = data[7:0];
      CFG_TARGET_WIDTH:  dst_w_reg = data;
      CFG_TARGET_HEIGHT: dst_h_reg = data;
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [11:0] pick_src();
    logic [3:0] junk;
    junk = 4'($urandom);
    case ($urandom_range(0, 9))
      0: return {junk, 8'd0};
      1: return 12'd1;
      2: return 12'd128;
      3: return {junk, 8'($urandom_range(129, 255))};
      4: return 12'd2;
      default: return {junk, 8'($urandom_range(1, 12))};
    endcase
  endfunction

  function automatic logic [11:0] pick_dst(logic [11:0] src);
    case ($urandom_range(0, 9))
      0: return 12'd0;
      1: return 12'd1;
      2: return 12'd4095;
      3: return 12'(eff_src(src[7:0]));
      4: return 12'($urandom_range(1, 4095));
      default: return 12'($urandom_range(1, 40));
    endcase
  endfunction

  // Compare each result against the oldest expectation
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && done) begin
      if (pending_px.size() == 0) begin
        report("result with no request pending");
      end else begin
        want = pending_px.pop_front();
        if (red_out !== want.red)
          report($sformatf("red_out %0h want %0h", red_out, want.red));
        if (green_out !== want.green)
          report($sformatf("green_out %0h want %0h", green_out, want.green));
        if (blue_out !== want.blue)
          report($sformatf("blue_out %0h want %0h", blue_out, want.blue));
        if (coord_error !== want.err)
          report($sformatf("coord_error %0b want %0b", coord_error, want.err));
      end
    end
  end

  initial begin
    dir_row_t rows [$];
    logic [11:0] sw_d, sh_d;
    int unsigned sw, sh, tw, th;
    bit [11:0] x, y;

    // Directed table under reset sizes (equal sizes, so pixels pass through)
    rows.push_back('{OP_LOAD, 12'd0, 12'd0, 8'hFF, 8'h00, 8'h80, 1'b0, '0});
    rows.push_back('{OP_LOAD, 12'd127, 12'd127, 8'h01, 8'hFE, 8'h7F, 1'b0, '0});
    rows.push_back('{OP_LOAD, 12'd127, 12'd0, 8'h55, 8'hAA, 8'h00, 1'b0, '0});
    rows.push_back('{OP_LOAD, 12'd0, 12'd127, 8'h00, 8'hFF, 8'hFF, 1'b0, '0});
    rows.push_back('{OP_LOAD, 12'd4095, 12'd4095, 8'h12, 8'h34, 8'h56, 1'b0, '0});
    rows.push_back('{OP_LOAD, 12'd128, 12'd0, 8'h12, 8'h34, 8'h56, 1'b0, '0});
    rows.push_back('{OP_LOAD, 12'd0, 12'd128, 8'h12, 8'h34, 8'h56, 1'b0, '0});
    rows.push_back('{OP_COMPUTE, 12'd0, 12'd0, 8'h0, 8'h0, 8'h0, 1'b1, '{8'hFF, 8'h00, 8'h80, 1'b0}});
    rows.push_back('{OP_COMPUTE, 12'd127, 12'd127, 8'hFF, 8'hFF, 8'hFF, 1'b1,
                     '{8'h01, 8'hFE, 8'h7F, 1'b0}});
    rows.push_back('{OP_COMPUTE, 12'd127, 12'd0, 8'h0, 8'h0, 8'h0, 1'b1, '{8'h55, 8'hAA, 8'h00, 1'b0}});
    rows.push_back('{OP_COMPUTE, 12'd0, 12'd127, 8'h0, 8'h0, 8'h0, 1'b1, '{8'h00, 8'hFF, 8'hFF, 1'b0}});
    rows.push_back('{OP_COMPUTE, 12'd128, 12'd0, 8'h0, 8'h0, 8'h0, 1'b1, '{8'h0, 8'h0, 8'h0, 1'b1}});
    rows.push_back('{OP_COMPUTE, 12'd0, 12'd128, 8'h0, 8'h0, 8'h0, 1'b1, '{8'h0, 8'h0, 8'h0, 1'b1}});
    rows.push_back('{OP_COMPUTE, 12'd4095, 12'd4095, 8'h0, 8'h0, 8'h0, 1'b1, '{8'h0, 8'h0, 8'h0, 1'b1}});
    rows.push_back('{OP_COMPUTE, 12'd0, 12'd0, 8'h0, 8'h0, 8'h0, 1'b0, '0});

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (rows[i]) begin
      send_request(rows[i].op, rows[i].x, rows[i].y, rows[i].r, rows[i].g, rows[i].b,
                   rows[i].typed, rows[i].want);
    end

    // Random phases, each under a fresh register setting
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      sw_d = pick_src();
      sh_d = (eff_src(sw_d[7:0]) == MAX_SRC_WIDTH) ? 12'($urandom_range(1, 6)) : pick_src();
      write_reg(CFG_SOURCE_WIDTH, sw_d);
      write_reg(CFG_SOURCE_HEIGHT, sh_d);
      write_reg(CFG_TARGET_WIDTH, pick_dst(sw_d));
      write_reg(CFG_TARGET_HEIGHT, pick_dst(sh_d));
      max_gap = (ph % 5 == 3) ? 0 : 10;
      sw = eff_src(src_w_reg);
      sh = eff_src(src_h_reg);
      tw = eff_dst(dst_w_reg);
      th = eff_dst(dst_h_reg);

      // Fill whatever part of the source window is still unwritten
      for (int yy = 0; yy < int'(sh); yy++) begin
        for (int xx = 0; xx < int'(sw); xx++) begin
          if (!written[yy * MAX_SRC_WIDTH + xx]) load_random(12'(xx), 12'(yy));
        end
      end

      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 4) begin
          if ($urandom_range(0, 9) < 6) load_random(12'($urandom_range(0, sw - 1)),
                                                    12'($urandom_range(0, sh - 1)));
          else load_random(12'($urandom), 12'($urandom));
        end else begin
          x = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'($urandom_range(0, tw - 1));
          y = ($urandom_range(0, 19) == 0) ? 12'($urandom) : 12'($urandom_range(0, th - 1));
          send_request(OP_COMPUTE, x, y, 8'($urandom), 8'($urandom), 8'($urandom), 1'b0, '0);
        end
      end
    end

    // Drain and decide
    wait_idle();
    if (fail_count == 0) begin
      $display("PASS rgb_image_scaler");
    end else begin
      $display("FAIL rgb_image_scaler");
    end
    $finish;
  end
endmodule
`default_nettype wire
